FILE: rtl/shared_frame_refcount_table_macros.svh
// assertion macros shared by the frame refcount table rtl
`ifndef SHARED_FRAME_REFCOUNT_TABLE_MACROS_SVH
`define SHARED_FRAME_REFCOUNT_TABLE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SFRT_ASSERT_IMP(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SFRT_ASSERT_NXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

FILE: rtl/sfrt_pkg.sv
// types and constants of the shared frame refcount table
`timescale 1ns / 1ps
`default_nettype none

package sfrt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int ACTION_W = 2;
	localparam int FILE_W   = 16;
	localparam int OFFSET_W = 31;
	localparam int FRAME_W  = 20;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [FILE_W-1:0]   file_id;
		logic [OFFSET_W-1:0] file_offset;
		logic [FRAME_W-1:0]  frame_number;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  found_frame;
		logic [COUNT_W-1:0]  share_count;
		logic                frame_freed;
	} rsp_word_t;

	typedef struct packed {
		logic [FILE_W-1:0]   file;
		logic [OFFSET_W-1:0] offset;
		logic [FRAME_W-1:0]  frame;
		logic [COUNT_W-1:0]  count;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

`default_nettype wire

FILE: rtl/sfrt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sfrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/shared_frame_refcount_table.sv
// Shared frame refcount table: TABLE_ENTRIES slots keyed by file and offset,
// each holding a frame number and a share count. Insert takes the lowest free
// slot, release finds the lowest slot with the frame and counts it down
// (removing it at zero), lookup finds the lowest slot with file and offset.
// Slot contents sit in one ram read one slot per cycle; valid marks are
// flip-flops cleared by reset, so the block is usable right after reset.
// Flow: a request is taken in S_IDLE; S_SCAN reads the slots from slot 0 on
// through the single ram read port and compares each in the idx_s1/cmp_v_s1
// stage, stopping at a hit or after the last slot, and registers the result
// in res_q; S_DONE moves it to the output register and returns to S_IDLE. No
// new request is taken before that; a result waiting on rsp_stall does not block
// taking the next request, only the move of the next result to the output.
`timescale 1ns / 1ps
`default_nettype none
`include "shared_frame_refcount_table_macros.svh"

module shared_frame_refcount_table
	import sfrt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]               state_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	req_word_t                req_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     issue_q;
	logic [IDX_W-1:0]         idx_s1;
	logic                     cmp_v_s1;
	rsp_word_t                res_q;
	rsp_word_t                rsp_q;
	logic                     rsp_valid_q;

	slot_t     rd_slot;
	slot_t     wr_slot;
	logic      wr_en;
	logic      req_fire;
	logic      slot_live;
	logic      hit;
	logic      finish;
	logic      count_low;
	logic      set_valid;
	logic      clr_valid;
	logic      out_free;
	rsp_word_t res_d;

	assign req_fire  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	sfrt_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (wr_slot),
		.re    (state_q == S_SCAN && issue_q),
		.raddr (idx_q),
		.rdata (rd_slot)
	);

	assign slot_live = valid_q[idx_s1];
	assign count_low = (rd_slot.count <= COUNT_ONE);

	always_comb begin
		case (req_q.action)
			ACT_INSERT:  hit = !slot_live;
			ACT_RELEASE: hit = slot_live && (rd_slot.frame == req_q.frame_number);
			ACT_LOOKUP:  hit = slot_live && (rd_slot.file == req_q.file_id)
				&& (rd_slot.offset == req_q.file_offset);
			default:     hit = 1'b0;
		endcase
	end

	assign finish = (state_q == S_SCAN) && cmp_v_s1 && (hit || idx_s1 == IDX_LAST);

	always_comb begin
		res_d     = '{status: ST_NOTFOUND, found_frame: '0, share_count: '0,
			frame_freed: 1'b0};
		wr_slot   = rd_slot;
		wr_en     = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		case (req_q.action)
			ACT_INSERT: begin
				wr_slot = '{file: req_q.file_id, offset: req_q.file_offset,
					frame: req_q.frame_number, count: COUNT_ONE};
				if (hit) begin
					res_d.status      = ST_OK;
					res_d.share_count = COUNT_ONE;
					wr_en             = finish;
					set_valid         = finish;
				end else begin
					res_d.status = ST_FULL;
				end
			end
			ACT_RELEASE: begin
				wr_slot.count = rd_slot.count - COUNT_ONE;
				if (hit) begin
					res_d.status = ST_OK;
					if (count_low) begin
						res_d.frame_freed = 1'b1;
						clr_valid         = finish;
					end else begin
						res_d.share_count = wr_slot.count;
						wr_en             = finish;
					end
				end
			end
			ACT_LOOKUP: begin
				if (hit) begin
					res_d.status      = ST_OK;
					res_d.found_frame = rd_slot.frame;
					res_d.share_count = rd_slot.count;
				end
			end
			default: begin
				res_d.status = ST_NOTFOUND;
			end
		endcase
	end

	// sequencer and scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			issue_q  <= 1'b0;
			cmp_v_s1 <= 1'b0;
			idx_q    <= '0;
			idx_s1   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q  <= S_SCAN;
						idx_q    <= '0;
						issue_q  <= 1'b1;
						cmp_v_s1 <= 1'b0;
					end
				end
				S_SCAN: begin
					cmp_v_s1 <= issue_q;
					idx_s1   <= idx_q;
					if (issue_q) begin
						if (idx_q == IDX_LAST) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					if (finish) begin
						state_q  <= S_DONE;
						issue_q  <= 1'b0;
						cmp_v_s1 <= 1'b0;
						if (set_valid) begin
							valid_q[idx_s1] <= 1'b1;
						end
						if (clr_valid) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		if (finish) begin
			res_q <= res_d;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SFRT_ASSERT_NXT(a_fire_starts_scan, req_fire,
		state_q == S_SCAN && idx_q == '0 && !cmp_v_s1, "request did not start a scan")
	`SFRT_ASSERT_IMP(a_cmp_in_scan, cmp_v_s1, state_q == S_SCAN,
		"compare stage live outside scan")
	`SFRT_ASSERT_NXT(a_insert_adds_one, finish && set_valid,
		$countones(valid_q) == $past($countones(valid_q)) + 1, "insert did not add a slot")
	`SFRT_ASSERT_NXT(a_release_frees_one, finish && clr_valid,
		$countones(valid_q) + 1 == $past($countones(valid_q)), "release did not free a slot")
	`SFRT_ASSERT_NXT(a_done_emits, state_q == S_DONE && out_free,
		rsp_valid && state_q == S_IDLE, "finished result not presented")

endmodule

`default_nettype wire

FILE: tb/shared_frame_refcount_table_tb.sv
// testbench for the shared frame refcount table: directed table, random traffic, predictor check
`timescale 1ns / 1ps

module shared_frame_refcount_table_tb;
	import sfrt_pkg::*;

	localparam int SLOTS = TABLE_ENTRIES_DEF;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 830;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RX_FREE = 0;
	localparam int RX_LIGHT = 1;
	localparam int RX_HEAVY = 2;
	localparam int RX_HOLD = 3;

	typedef struct {
		req_word_t w;
		bit        typed;
		rsp_word_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	// shadow of the slot table
	logic                tbl_valid [SLOTS];
	logic [FILE_W-1:0]   tbl_file [SLOTS];
	logic [OFFSET_W-1:0] tbl_offset [SLOTS];
	logic [FRAME_W-1:0]  tbl_frame [SLOTS];
	logic [COUNT_W-1:0]  tbl_count [SLOTS];

	rsp_word_t owed_responses [$];
	dir_row_t  dir_rows [$];
	logic [FILE_W-1:0]   file_pool [8];
	logic [OFFSET_W-1:0] off_pool [8];
	logic [FRAME_W-1:0]  frame_pool [8];

	int errors = 0;
	int cycles = 0;
	int stall_mode = RX_FREE;
	int stall_left = 0;

	shared_frame_refcount_table #(
		.TABLE_ENTRIES(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic req_word_t mk_req(logic [ACTION_W-1:0] a, logic [FILE_W-1:0] f,
			logic [OFFSET_W-1:0] o, logic [FRAME_W-1:0] fr);
		req_word_t w;
		w.action = a;
		w.file_id = f;
		w.file_offset = o;
		w.frame_number = fr;
		return w;
	endfunction

	function automatic rsp_word_t mk_rsp(logic [STATUS_W-1:0] s, logic [FRAME_W-1:0] fr,
			logic [COUNT_W-1:0] c, logic freed);
		rsp_word_t r;
		r.status = s;
		r.found_frame = fr;
		r.share_count = c;
		r.frame_freed = freed;
		return r;
	endfunction

	// applies one accepted request to the shadow table and returns its response word
	function automatic rsp_word_t resolve_request(req_word_t w);
		rsp_word_t r;
		int hit;
		r = mk_rsp(ST_NOTFOUND, '0, '0, 1'b0);
		hit = -1;
		case (w.action)
			ACT_INSERT: begin
				for (int i = 0; i < SLOTS && hit < 0; i++)
					if (!tbl_valid[i])
						hit = i;
				if (hit < 0) begin
					r.status = ST_FULL;
				end else begin
					tbl_valid[hit] = 1'b1;
					tbl_file[hit] = w.file_id;
					tbl_offset[hit] = w.file_offset;
					tbl_frame[hit] = w.frame_number;
					tbl_count[hit] = COUNT_ONE;
					r.status = ST_OK;
					r.share_count = COUNT_ONE;
				end
			end
			ACT_RELEASE: begin
				for (int i = 0; i < SLOTS && hit < 0; i++)
					if (tbl_valid[i] && tbl_frame[i] == w.frame_number)
						hit = i;
				if (hit >= 0) begin
					r.status = ST_OK;
					if (tbl_count[hit] <= COUNT_ONE) begin
						tbl_valid[hit] = 1'b0;
						tbl_count[hit] = '0;
						r.frame_freed = 1'b1;
					end else begin
						tbl_count[hit] = tbl_count[hit] - COUNT_ONE;
						r.share_count = tbl_count[hit];
					end
				end
			end
			ACT_LOOKUP: begin
				for (int i = 0; i < SLOTS && hit < 0; i++)
					if (tbl_valid[i] && tbl_file[i] == w.file_id
							&& tbl_offset[i] == w.file_offset)
						hit = i;
				if (hit >= 0) begin
					r.status = ST_OK;
					r.found_frame = tbl_frame[hit];
					r.share_count = tbl_count[hit];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int pick_live_slot();
		int start;
		int idx;
		int found;
		found = -1;
		start = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			idx = (start + k) % SLOTS;
			if (tbl_valid[idx] && found < 0)
				found = idx;
		end
		return found;
	endfunction

	// mostly hits on live slots; the bias moves the table toward full or empty
	function automatic req_word_t random_request(bit filling);
		req_word_t w;
		int roll;
		int live;
		int ins_cut;
		int rel_cut;
		ins_cut = filling ? 55 : 22;
		rel_cut = ins_cut + (filling ? 20 : 50);
		w.file_id = ($urandom_range(0, 3) == 0) ? FILE_W'($urandom)
			: file_pool[$urandom_range(0, 7)];
		w.file_offset = ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom)
			: off_pool[$urandom_range(0, 7)];
		w.frame_number = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom)
			: frame_pool[$urandom_range(0, 7)];
		roll = $urandom_range(0, 99);
		live = pick_live_slot();
		if (roll < ins_cut) begin
			w.action = ACT_INSERT;
		end else if (roll < rel_cut) begin
			w.action = ACT_RELEASE;
			if (live >= 0 && $urandom_range(0, 9) < 8)
				w.frame_number = tbl_frame[live];
		end else if (roll < 97) begin
			w.action = ACT_LOOKUP;
			if (live >= 0 && $urandom_range(0, 9) < 8) begin
				w.file_id = tbl_file[live];
				if ($urandom_range(0, 7) != 0)
					w.file_offset = tbl_offset[live];
			end
		end else begin
			w.action = ACT_UNUSED;
		end
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic send_word(req_word_t w, bit typed, rsp_word_t want);
		rsp_word_t predicted;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		predicted = resolve_request(w);
		owed_responses.push_back(typed ? want : predicted);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (owed_responses.size() != 0)
			@(posedge clk);
	endtask

	// response side
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(RX_FREE, RX_HOLD);
			stall_left = (stall_mode == RX_HOLD) ? $urandom_range(4, 40)
				: $urandom_range(20, 160);
		end
		stall_left--;
		case (stall_mode)
			RX_FREE:  rsp_stall <= 1'b0;
			RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
			default:  rsp_stall <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_responses.size() == 0) begin
				report_mismatch($sformatf("unexpected response word %h", rsp));
			end else begin
				want = owed_responses.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
				if (rsp.found_frame !== want.found_frame)
					report_mismatch($sformatf("found_frame %h, want %h",
						rsp.found_frame, want.found_frame));
				if (rsp.share_count !== want.share_count)
					report_mismatch($sformatf("share_count %0d, want %0d",
						rsp.share_count, want.share_count));
				if (rsp.frame_freed !== want.frame_freed)
					report_mismatch($sformatf("frame_freed %b, want %b",
						rsp.frame_freed, want.frame_freed));
			end
		end
	end

	initial begin
		int burst_left;
		bit filling;
		rsp_word_t none;
		none = '0;
		burst_left = 0;
		filling = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_file[i] = '0;
			tbl_offset[i] = '0;
			tbl_frame[i] = '0;
			tbl_count[i] = '0;
		end
		file_pool[0] = '0;
		file_pool[1] = '1;
		off_pool[0] = '0;
		off_pool[1] = '1;
		frame_pool[0] = '0;
		frame_pool[1] = '1;
		for (int i = 2; i < 8; i++) begin
			file_pool[i] = FILE_W'($urandom);
			off_pool[i] = OFFSET_W'($urandom);
			frame_pool[i] = FRAME_W'($urandom);
		end

		// extremes, every action, duplicates, fill to full
		dir_rows.push_back('{mk_req(ACT_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 20'h0), 1'b1,
			mk_rsp(ST_NOTFOUND, '0, '0, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_RELEASE, 16'h0, 31'h0, 20'h0), 1'b1,
			mk_rsp(ST_NOTFOUND, '0, '0, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_UNUSED, 16'hFFFF, 31'h7FFFFFFF, 20'hFFFFF), 1'b1,
			mk_rsp(ST_NOTFOUND, '0, '0, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_INSERT, 16'hFFFF, 31'h7FFFFFFF, 20'hFFFFF), 1'b1,
			mk_rsp(ST_OK, '0, COUNT_ONE, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_LOOKUP, 16'hFFFF, 31'h7FFFFFFF, 20'h0), 1'b1,
			mk_rsp(ST_OK, 20'hFFFFF, COUNT_ONE, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_INSERT, 16'h0, 31'h0, 20'h0), 1'b1,
			mk_rsp(ST_OK, '0, COUNT_ONE, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_INSERT, 16'h0, 31'h0, 20'h5), 1'b1,
			mk_rsp(ST_OK, '0, COUNT_ONE, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_LOOKUP, 16'h0, 31'h0, 20'hFFFFF), 1'b0, none});
		dir_rows.push_back('{mk_req(ACT_LOOKUP, 16'hFFFF, 31'h0, 20'h0), 1'b0, none});
		dir_rows.push_back('{mk_req(ACT_RELEASE, 16'h0, 31'h0, 20'hFFFFF), 1'b1,
			mk_rsp(ST_OK, '0, '0, 1'b1)});
		dir_rows.push_back('{mk_req(ACT_RELEASE, 16'hFFFF, 31'h7FFFFFFF, 20'hFFFFF), 1'b1,
			mk_rsp(ST_NOTFOUND, '0, '0, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_INSERT, 16'h1234, 31'h1000, 20'h5), 1'b0, none});
		for (int i = 3; i < SLOTS; i++)
			dir_rows.push_back('{mk_req(ACT_INSERT, FILE_W'(i), OFFSET_W'($urandom),
				FRAME_W'($urandom)), 1'b0, none});
		dir_rows.push_back('{mk_req(ACT_INSERT, 16'hFFFF, 31'h7FFFFFFF, 20'hFFFFF), 1'b1,
			mk_rsp(ST_FULL, '0, '0, 1'b0)});
		dir_rows.push_back('{mk_req(ACT_RELEASE, 16'h0, 31'h0, 20'h5), 1'b0, none});
		dir_rows.push_back('{mk_req(ACT_INSERT, 16'h5A5A, 31'h2AAAAAAA, 20'hAAAAA), 1'b0, none});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
		hold_until_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				filling = !filling;
			if (n == RANDOM_ITEMS / 2)
				hold_until_drained();
			if (burst_left == 0) begin
				idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10));
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
			send_word(random_request(filling), 1'b0, none);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (owed_responses.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 6) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
